// ===== sv/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the spin asymmetry calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

	localparam int CNT_W      = 24;  // input count field width
	localparam int OUT_W      = 20;  // result field width, also quotient bits
	localparam int POL_W      = 16;  // polarization width, all fraction bits
	localparam int GUARD      = 16;  // guard fraction bits on square roots
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POL  = 2'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_PLAIN = 2'd0,
		MODE_PHYS  = 2'd1,
		MODE_GEOM  = 2'd2,
		MODE_LUMI  = 2'd3
	} mode_t;

	localparam mode_t            MODE_RESET = MODE_PLAIN;
	localparam logic [POL_W-1:0] POL_RESET  = 16'd34538;

	typedef struct packed {
		logic [CNT_W-1:0] count_up_left;
		logic [CNT_W-1:0] count_up_right;
		logic [CNT_W-1:0] count_down_left;
		logic [CNT_W-1:0] count_down_right;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] asym_value;
		logic        [OUT_W-1:0] asym_error;
		logic                    result_valid;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/spin_asymmetry_calculator_core.sv =====
// ----------------------------------------------------------------------------
// spin_asymmetry_calculator_core
// Spin asymmetry and its statistical error from four bin counts, plain or
// square-root formula, fixed point out, fully pipelined.
// ----------------------------------------------------------------------------
//
//  port group               dir  handshake           payload
//  start/busy/item          in   start & !busy       sac_pkg::item_t
//  done/result              out  done, 1-cycle pulse sac_pkg::result_t
//  cfg_valid/cfg_ready/...  in   valid & ready       cfg_index, cfg_data
//
//  One word in per clock, one result word out per accepted word, in order.
//  The result path runs through the error radicand products, the wide error
//  square root and the 20-bit error divider; the x/y roots and denominator
//  products run beside it, and each unit resolves one bit per stage.
//  busy never rises and the result side cannot stall, so nothing is held.
//  Reset clears the valid line and loads the register defaults.
//
`default_nettype none

module spin_asymmetry_calculator_core #(
	parameter int COUNT_WIDTH = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  sac_pkg::item_t                    item,
	output logic                              done,
	output sac_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sac_pkg::*;

	// ---- widths -------------------------------------------------------------
	localparam int CW     = COUNT_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int G      = GUARD;
	localparam int P      = POL_W;
	localparam int SW     = CW + 1;               // count sum
	localparam int XW     = 2 * CW;               // count product
	localparam int PPW    = XW + 1;               // partial product
	localparam int LXY    = CW + G;               // root bits of x*2^2G
	localparam int XR_W   = 2 * LXY;
	localparam int IN_W   = 3 * CW + 2;           // error radicand core
	localparam int RSH    = (2 * G > 2 * F + 2) ? 2 * G : 2 * F + 2;
	localparam int RAD_W  = IN_W + RSH;
	localparam int NQ     = (RAD_W + 1) / 2;      // root bits of error radicand
	localparam int DNW    = LXY + 1;              // denominator sum
	localparam int DFW    = LXY;                  // value difference
	localparam int DLO    = DNW / 2;
	localparam int HDW    = DNW + P;
	localparam int VSH_S  = F + P + 1;
	localparam int VSH_P  = F + 1;
	localparam int VN_W   = DFW + VSH_S + 1;
	localparam int VD_W   = HDW + 1;
	localparam int DN2W   = 2 * DNW;
	localparam int DEW    = DN2W + P;
	localparam int ESH    = G + F + P;
	localparam int EN_W   = NQ + ESH;
	localparam int PKW    = CW + SW + 2;

	// ---- pipeline timing ----------------------------------------------------
	localparam int K_XY = 2 + LXY;                // x/y roots ready
	localparam int K_N  = 4 + NQ;                 // error root ready
	localparam int LA   = K_N - (K_XY + 5);       // error denominator wait
	localparam int LV   = LA + 3;                 // value quotient wait
	localparam int LF   = LV + OUT_W;             // flags from stage 7
	localparam int K_E  = K_N + 1 + OUT_W;        // error quotient ready
	localparam int LAT  = K_E + 1;

	localparam logic [OUT_W-1:0] ONE_ERR = (F < OUT_W) ? (OUT_W'(1) << F) : '1;
	localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};
	localparam int               PLAIN_LIM = (F < 30) ? (1 << F) : 1 << 30;

	// ---- configuration ------------------------------------------------------
	mode_t            mode_q;
	logic [P-1:0]     pol_q;
	logic             plain;
	logic [P-1:0]     pol_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			pol_q  <= POL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_POL:  pol_q  <= cfg_data[P-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign plain     = (mode_q == MODE_PLAIN);
	// plain mode runs the shared products with a unit scale
	assign pol_eff   = (plain || pol_q == '0) ? P'(1) : pol_q;

	// ---- valid line ---------------------------------------------------------
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	// ---- s1: operand routing by mode ----------------------------------------
	logic [CW-1:0] ul, ur, dl, dr;
	logic [CW-1:0] a_s1, b_s1, c_s1, d_s1;

	assign ul = CW'(item.count_up_left);
	assign ur = CW'(item.count_up_right);
	assign dl = CW'(item.count_down_left);
	assign dr = CW'(item.count_down_right);

	always_ff @(posedge clk) begin
		case (mode_q)
			MODE_PHYS: begin
				a_s1 <= ur; b_s1 <= dl; c_s1 <= ul; d_s1 <= dr;
			end
			MODE_GEOM: begin
				a_s1 <= ur; b_s1 <= dr; c_s1 <= ul; d_s1 <= dl;
			end
			MODE_LUMI: begin
				a_s1 <= ur; b_s1 <= ul; c_s1 <= dl; d_s1 <= dr;
			end
			default: begin
				// plain: a=U, b=D, so x=UD, y=0, a+b is the sum
				a_s1 <= ul; b_s1 <= dl; c_s1 <= '0; d_s1 <= '0;
			end
		endcase
	end

	// ---- s2: products, sums, plain difference -------------------------------
	logic [XW-1:0] x_s2, y_s2;
	logic [SW-1:0] abs_s2, cds_s2;
	logic [CW-1:0] pdiff_s2;
	logic          pneg_s2, pzero_s2;

	always_ff @(posedge clk) begin
		x_s2     <= XW'(a_s1) * XW'(b_s1);
		y_s2     <= XW'(c_s1) * XW'(d_s1);
		abs_s2   <= SW'(a_s1) + SW'(b_s1);
		cds_s2   <= SW'(c_s1) + SW'(d_s1);
		pneg_s2  <= (b_s1 > a_s1);
		pdiff_s2 <= (b_s1 > a_s1) ? (b_s1 - a_s1) : (a_s1 - b_s1);
		pzero_s2 <= (a_s1 == '0) || (b_s1 == '0);
	end

	// ---- s3/s4: error radicand x*(c+d) + y*(a+b), plain x*(U+D) -------------
	logic [SW-1:0]  msel;
	logic [PPW-1:0] p1_s3, p2_s3, p3_s3, p4_s3;
	logic [IN_W-1:0] inner_s4;

	assign msel = plain ? abs_s2 : cds_s2;

	always_ff @(posedge clk) begin
		p1_s3 <= PPW'(x_s2[CW-1:0])  * PPW'(msel);
		p2_s3 <= PPW'(x_s2[XW-1:CW]) * PPW'(msel);
		p3_s3 <= PPW'(y_s2[CW-1:0])  * PPW'(abs_s2);
		p4_s3 <= PPW'(y_s2[XW-1:CW]) * PPW'(abs_s2);
		inner_s4 <= IN_W'(p1_s3) + (IN_W'(p2_s3) << CW)
			+ IN_W'(p3_s3) + (IN_W'(p4_s3) << CW);
	end

	// ---- square roots -------------------------------------------------------
	logic [XR_W-1:0]  xr, yr;
	logic [RAD_W-1:0] rad;
	logic [LXY-1:0]   sx, sy;
	logic [NQ-1:0]    nn;

	assign xr  = XR_W'(x_s2) << (2 * G);
	assign yr  = XR_W'(y_s2) << (2 * G);
	assign rad = plain ? (RAD_W'(inner_s4) << (2 * F + 2)) : (RAD_W'(inner_s4) << (2 * G));

	sac_digit_pipe #(.IS_SQRT(1'b1), .NW(XR_W), .DW(1), .QW(LXY)) u_sqrt_x (
		.clk (clk), .num (xr), .den (1'b0), .q (sx)
	);

	sac_digit_pipe #(.IS_SQRT(1'b1), .NW(XR_W), .DW(1), .QW(LXY)) u_sqrt_y (
		.clk (clk), .num (yr), .den (1'b0), .q (sy)
	);

	sac_digit_pipe #(.IS_SQRT(1'b1), .NW(RAD_W), .DW(1), .QW(NQ)) u_sqrt_n (
		.clk (clk), .num (rad), .den (1'b0), .q (nn)
	);

	// plain-mode terms ride alongside the x/y roots
	logic [PKW-1:0] pk_q [LXY];
	logic [CW-1:0]  pdiff_d;
	logic [SW-1:0]  psum_d;
	logic           pneg_d, pzero_d;

	always_ff @(posedge clk) begin
		pk_q[0] <= {pdiff_s2, abs_s2, pneg_s2, pzero_s2};
		for (int i = 1; i < LXY; i++) pk_q[i] <= pk_q[i-1];
	end

	assign {pdiff_d, psum_d, pneg_d, pzero_d} = pk_q[LXY-1];

	// ---- s5..s9: denominators -----------------------------------------------
	logic [DNW-1:0]  dnm_s5;
	logic [DFW-1:0]  diff_s5, diff_s6;
	logic            neg_s5, neg_s6, neg_s7;
	logic            pz_s5, pz_s6, pz_s7;
	logic            nz_s6, nz_s7;
	logic [HDW-1:0]  hd_s6;
	logic [DN2W-1:0] dlo_s6, dhi_s6, dn2_s7;
	logic [VN_W-1:0] vnum_s7;
	logic [VD_W-1:0] vden_s7;
	logic [DEW-1:0]  elo_s8, ehi_s8, de_s9;

	always_ff @(posedge clk) begin
		if (plain) begin
			dnm_s5  <= DNW'(psum_d);
			diff_s5 <= DFW'(pdiff_d);
			neg_s5  <= pneg_d;
			pz_s5   <= pzero_d;
		end else begin
			dnm_s5  <= DNW'(sx) + DNW'(sy);
			diff_s5 <= (sx > sy) ? (sx - sy) : (sy - sx);
			neg_s5  <= (sx > sy);
			pz_s5   <= 1'b0;
		end

		hd_s6   <= HDW'(dnm_s5) * HDW'(pol_eff);
		dlo_s6  <= DN2W'(dnm_s5) * DN2W'(dnm_s5[DLO-1:0]);
		dhi_s6  <= DN2W'(dnm_s5) * DN2W'(dnm_s5[DNW-1:DLO]);
		diff_s6 <= diff_s5;
		neg_s6  <= neg_s5;
		pz_s6   <= pz_s5;
		nz_s6   <= (dnm_s5 != '0);

		// rounded quotient: (diff*2^k + den) / (2*den)
		vnum_s7 <= (VN_W'(diff_s6) << (plain ? VSH_P : VSH_S)) + VN_W'(hd_s6);
		vden_s7 <= VD_W'(hd_s6) << 1;
		dn2_s7  <= dlo_s6 + (dhi_s6 << DLO);
		neg_s7  <= neg_s6;
		pz_s7   <= pz_s6;
		nz_s7   <= nz_s6;

		elo_s8  <= DEW'(dn2_s7[DNW-1:0])    * DEW'(pol_eff);
		ehi_s8  <= DEW'(dn2_s7[DN2W-1:DNW]) * DEW'(pol_eff);
		de_s9   <= elo_s8 + (ehi_s8 << DNW);
	end

	// ---- value quotient -----------------------------------------------------
	logic [OUT_W-1:0] vq;

	sac_digit_pipe #(.IS_SQRT(1'b0), .NW(VN_W), .DW(VD_W), .QW(OUT_W)) u_div_val (
		.clk (clk), .num (vnum_s7), .den (vden_s7), .q (vq)
	);

	// ---- s10: error quotient operands ---------------------------------------
	logic [DEW-1:0]  de_q [LA];
	logic [EN_W-1:0] en_s10;
	logic [DEW-1:0]  ed_s10;
	logic [OUT_W-1:0] eq;

	always_ff @(posedge clk) begin
		de_q[0] <= de_s9;
		for (int i = 1; i < LA; i++) de_q[i] <= de_q[i-1];
		en_s10 <= plain ? EN_W'(nn) : (EN_W'(nn) << ESH);
		ed_s10 <= de_q[LA-1];
	end

	sac_digit_pipe #(.IS_SQRT(1'b0), .NW(EN_W), .DW(DEW), .QW(OUT_W)) u_div_err (
		.clk (clk), .num (en_s10), .den (ed_s10), .q (eq)
	);

	// ---- alignment of value and flags with the error quotient ---------------
	logic [OUT_W-1:0] vq_q [LV];
	logic [2:0]       fl_q [LF];
	logic             neg_f, pz_f, nz_f;
	logic [OUT_W-1:0] vmag;

	always_ff @(posedge clk) begin
		vq_q[0] <= vq;
		for (int i = 1; i < LV; i++) vq_q[i] <= vq_q[i-1];
		fl_q[0] <= {neg_s7, pz_s7, nz_s7};
		for (int i = 1; i < LF; i++) fl_q[i] <= fl_q[i-1];
	end

	assign {neg_f, pz_f, nz_f} = fl_q[LF-1];

	always_comb begin
		if (neg_f) begin
			vmag = (vq_q[LV-1] > NEG_MAX) ? NEG_MAX : vq_q[LV-1];
		end else begin
			vmag = (vq_q[LV-1] > POS_MAX) ? POS_MAX : vq_q[LV-1];
		end
	end

	// ---- output word --------------------------------------------------------
	result_t res_q;

	always_ff @(posedge clk) begin
		if (!nz_f) begin
			res_q <= '0;
		end else begin
			res_q.asym_value   <= neg_f ? (OUT_W'(0) - vmag) : vmag;
			res_q.asym_error   <= pz_f ? ONE_ERR : eq;
			res_q.result_valid <= 1'b1;
		end
	end

	assign result = res_q;

	// ---- checks -------------------------------------------------------------
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted word did not complete after LAT cycles");

	a_invalid_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.result_valid |-> result.asym_value == '0 && result.asym_error == '0)
		else $error("invalid result carries nonzero fields");

	a_plain_bound : assert property (@(posedge clk) disable iff (!arst_n)
		done && mode_q == MODE_PLAIN && result.result_valid
		|-> (int'(result.asym_value) <= PLAIN_LIM) && (int'(result.asym_value) >= -PLAIN_LIM))
		else $error("plain asymmetry outside [-1, 1]");

endmodule

`default_nettype wire

// ===== sv/sac_digit_pipe.sv =====
// ----------------------------------------------------------------------------
// sac_digit_pipe
// Pipelined restoring recurrence, one result bit per stage: integer square
// root of num, or saturating quotient num/den (all ones on overflow).
// ----------------------------------------------------------------------------
`default_nettype none

module sac_digit_pipe #(
	parameter bit IS_SQRT = 1'b0,
	parameter int NW      = 8,
	parameter int DW      = 8,
	parameter int QW      = 4
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,   // tied to zero for a square root
	output logic [QW-1:0] q
);
	localparam int W0 = (NW > DW + QW) ? NW : DW + QW;
	localparam int TW = ((W0 > 2 * QW + 1) ? W0 : 2 * QW + 1) + 1;

	logic [TW-1:0] rem_q [1:QW-1];
	logic [DW-1:0] den_q [1:QW-1];
	logic [QW-1:0] acc_q [1:QW];
	logic          sat_q [1:QW];
	logic          sat_in;

	// quotient would not fit in QW bits
	assign sat_in = !IS_SQRT && (TW'(num) >= (TW'(den) << QW));

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int K = QW - 1 - i;
		logic [TW-1:0] rem_c;
		logic [TW-1:0] trial;
		logic [QW-1:0] acc_c;
		logic [DW-1:0] den_c;
		logic          sat_c;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_c = TW'(num);
			assign acc_c = '0;
			assign den_c = den;
			assign sat_c = sat_in;
		end else begin : g_next
			assign rem_c = rem_q[i];
			assign acc_c = acc_q[i];
			assign den_c = den_q[i];
			assign sat_c = sat_q[i];
		end

		// sqrt: (2*acc + 2^K) * 2^K ; divide: den * 2^K
		assign trial = (TW'(den_c) << K)
			+ (IS_SQRT ? ((TW'(acc_c) << (K + 1)) + (TW'(1) << (2 * K))) : '0);
		assign take = (rem_c >= trial);

		always_ff @(posedge clk) begin
			acc_q[i+1] <= take ? (acc_c | (QW'(1) << K)) : acc_c;
			sat_q[i+1] <= sat_c;
		end

		if (i < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_q[i+1] <= take ? (rem_c - trial) : rem_c;
				den_q[i+1] <= den_c;
			end
		end
	end

	assign q = sat_q[QW] ? '1 : acc_q[QW];

endmodule

`default_nettype wire

// ===== sim/tb_spin_asymmetry_calculator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spin_asymmetry_calculator_core
// Self-checking bench for the spin asymmetry core. A directed table covers
// the count extremes, zero denominators, empty-count errors, saturation and
// the polarization corner cases, spread over the four modes; random phases
// follow, each under its own mode and polarization. Each result word is
// compared with a typed expectation or a local wide-integer datapath model.
// ----------------------------------------------------------------------------

module tb_spin_asymmetry_calculator_core;

	import sac_pkg::*;

	typedef logic [255:0] wide_t;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // unmapped, must be ignored
	localparam logic [CNT_W-1:0]     CNT_MAX   = {CNT_W{1'b1}};
	localparam int                   TAIL_CYC  = 120;   // longer than the pipeline latency
	localparam int                   WDOG_LIM  = 4000;
	localparam int                   FRAC_BITS_TB = 16;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             done;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	spin_asymmetry_calculator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// shadow copy of the block's registers
	mode_t            cur_mode;
	logic [POL_W-1:0] cur_pol;

	result_t asym_due_q[$];   // expected result words, oldest first
	int      n_fail;
	int      n_items;
	int      n_results;
	int      n_cfg;
	int      n_invalid;
	int      idle_cnt;
	bit      no_gaps;         // burst stretch: start held high back to back

	// ------------------------------------------------------------------
	// arithmetic model
	// ------------------------------------------------------------------
	function automatic wide_t isqrt(input wide_t n);
		wide_t r;
		wide_t t;
		r = '0;
		for (int k = 127; k >= 0; k--) begin
			t = r | (wide_t'(1) << k);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] clamp_signed(input bit neg, input wide_t mag);
		wide_t m;
		m = mag;
		if (neg) begin
			if (m > 524288)
				m = 524288;
			return -m[OUT_W-1:0];
		end
		if (m > 524287)
			m = 524287;
		return m[OUT_W-1:0];
	endfunction

	function automatic result_t calc_asym(input item_t it, input mode_t md,
			input logic [POL_W-1:0] pol);
		result_t r;
		wide_t ul, ur, dl, dr, a, b, c, d;
		wide_t s, diff, q, e2, x, y, sx, sy, dn, p, den, inner, nn;
		bit    neg;
		r  = '0;
		ul = wide_t'(it.count_up_left);
		ur = wide_t'(it.count_up_right);
		dl = wide_t'(it.count_down_left);
		dr = wide_t'(it.count_down_right);
		if (md == MODE_PLAIN) begin
			s = ul + dl;
			if (s != 0) begin
				neg  = dl > ul;
				diff = neg ? dl - ul : ul - dl;
				q    = ((diff << FRAC_BITS_TB) * 2 + s) / (2 * s);
				r.asym_value = clamp_signed(neg, q);
				if (ul == 0 || dl == 0) begin
					r.asym_error = OUT_W'(1 << FRAC_BITS_TB);
				end else begin
					e2 = ((ul * dl) << (2 + 2 * FRAC_BITS_TB)) / (s * s * s);
					if (e2 > (wide_t'(1) << 32))
						e2 = wide_t'(1) << 32;
					q = isqrt(e2);
					r.asym_error = (q > 1048575) ? '1 : q[OUT_W-1:0];
				end
				r.result_valid = 1'b1;
			end
		end else begin
			a = ur;
			case (md)
				MODE_PHYS: begin b = dl; c = ul; d = dr; end
				MODE_GEOM: begin b = dr; c = ul; d = dl; end
				default:   begin b = ul; c = dl; d = dr; end
			endcase
			x  = a * b;
			y  = c * d;
			sx = isqrt(x << (2 * GUARD));
			sy = isqrt(y << (2 * GUARD));
			dn = sx + sy;
			if (dn != 0) begin
				neg  = sx > sy;
				diff = neg ? sx - sy : sy - sx;
				p    = (pol == 0) ? 1 : wide_t'(pol);
				den  = dn * p;
				q    = ((diff << (FRAC_BITS_TB + POL_W + 1)) + den) / (den << 1);
				r.asym_value = clamp_signed(neg, q);
				inner = x * (c + d) + y * (a + b);
				nn    = isqrt(inner << (2 * GUARD));
				q     = (nn << (GUARD + FRAC_BITS_TB + POL_W)) / (dn * dn * p);
				r.asym_error   = (q > 1048575) ? '1 : q[OUT_W-1:0];
				r.result_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checker: done is a one-cycle strobe, no back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			n_results++;
			if (!result.result_valid)
				n_invalid++;
			if (asym_due_q.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected result word %h", $time, result);
			end else begin
				want = asym_due_q.pop_front();
				if (result.asym_value !== want.asym_value) begin
					n_fail++;
					$display("%0t: asym_value exp %0d got %0d", $time,
						want.asym_value, result.asym_value);
				end
				if (result.asym_error !== want.asym_error) begin
					n_fail++;
					$display("%0t: asym_error exp %0d got %0d", $time,
						want.asym_error, result.asym_error);
				end
				if (result.result_valid !== want.result_valid) begin
					n_fail++;
					$display("%0t: result_valid exp %b got %b", $time,
						want.result_valid, result.result_valid);
				end
			end
		end
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIM) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				asym_due_q.size());
			$display("spin_asymmetry_calculator_core regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one word in; exp_given selects a hand-typed expectation
	task automatic send_counts(input item_t it, input bit exp_given, input result_t exp_word);
		int gap;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		asym_due_q.push_back(exp_given ? exp_word : calc_asym(it, cur_mode, cur_pol));
		n_items++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register write, only once the pipeline has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		while (asym_due_q.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_cfg++;
		if (idx == REG_MODE)
			cur_mode = mode_t'(val[MODE_W-1:0]);
		else if (idx == REG_POL)
			cur_pol = val[POL_W-1:0];
	endtask

	task automatic set_cfg(input mode_t md, input logic [POL_W-1:0] pol);
		if (md != cur_mode)
			write_reg(REG_MODE, CFG_DATA_W'(md));
		if (pol != cur_pol)
			write_reg(REG_POL, pol);
	endtask

	function automatic logic [CNT_W-1:0] rand_count();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CNT_W'($urandom_range(1, 15));
			2:       return CNT_MAX - CNT_W'($urandom_range(0, 15));
			3:       return CNT_W'($urandom_range(0, 4095));
			default: return CNT_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	typedef struct {
		mode_t            md;
		logic [POL_W-1:0] pol;
		logic [CNT_W-1:0] ul, ur, dl, dr;
		bit               typed;   // expectation written in below
		result_t          exp;
	} dir_row_t;

	localparam result_t R_NONE = '{asym_value: '0, asym_error: '0, result_valid: 1'b0};

	dir_row_t dir_tab[$] = '{
		// plain mode at reset settings
		'{MODE_PLAIN, POL_RESET, 0, 0, 0, 0, 1, R_NONE},
		'{MODE_PLAIN, POL_RESET, CNT_MAX, CNT_MAX, 0, CNT_MAX, 1,
			'{20'sd65536, 20'd65536, 1'b1}},                 // empty down count
		'{MODE_PLAIN, POL_RESET, 0, 0, CNT_MAX, 0, 1,
			'{-20'sd65536, 20'd65536, 1'b1}},                // empty up count
		'{MODE_PLAIN, POL_RESET, CNT_MAX, 0, CNT_MAX, 0, 1,
			'{20'sd0, 20'd11, 1'b1}},
		'{MODE_PLAIN, POL_RESET, 1, CNT_MAX, 1, CNT_MAX, 1,
			'{20'sd0, 20'd46340, 1'b1}},
		'{MODE_PLAIN, POL_RESET, 3, 0, 1, 0, 0, R_NONE},        // asymmetry of one half
		'{MODE_PLAIN, POL_RESET, CNT_MAX, 7, 1, 9, 0, R_NONE},
		// square-root modes: zero denominator, one side empty, extremes
		'{MODE_PHYS, POL_RESET, 0, 0, 0, 0, 1, R_NONE},
		'{MODE_PHYS, POL_RESET, 5, 0, CNT_MAX, 0, 1, R_NONE},   // A*B and C*D zero
		'{MODE_PHYS, POL_RESET, CNT_MAX, 0, 3, CNT_MAX, 0, R_NONE},
		'{MODE_PHYS, POL_RESET, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 0, R_NONE},
		'{MODE_GEOM, 16'hFFFF, 0, 0, 0, 0, 1, R_NONE},
		'{MODE_GEOM, 16'hFFFF, 1, CNT_MAX, 1, CNT_MAX, 0, R_NONE},
		'{MODE_GEOM, 16'hFFFF, CNT_MAX, 1, CNT_MAX, 1, 0, R_NONE},
		'{MODE_LUMI, 16'd1, 0, 0, 0, 0, 1, R_NONE},
		'{MODE_LUMI, 16'd1, CNT_MAX, CNT_MAX, 0, 0, 0, R_NONE},  // saturation
		'{MODE_LUMI, 16'd1, 0, CNT_MAX, 1, 1, 0, R_NONE},
		'{MODE_LUMI, 16'd0, 4, 2, 9, 1, 0, R_NONE},             // polarization 0
		'{MODE_LUMI, 16'd0, 100, 300, 200, 50, 0, R_NONE},
		'{MODE_PLAIN, 16'd0, CNT_MAX, CNT_MAX, CNT_MAX - 1, 0, 0, R_NONE}
	};

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		item_t it;
		mode_t md;
		logic [POL_W-1:0] pol;
		int    tail;

		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		n_fail    = 0;
		n_items   = 0;
		n_results = 0;
		n_cfg     = 0;
		n_invalid = 0;
		idle_cnt  = 0;
		no_gaps   = 1'b0;
		cur_mode  = MODE_RESET;
		cur_pol   = POL_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			set_cfg(dir_tab[i].md, dir_tab[i].pol);
			it = '{dir_tab[i].ul, dir_tab[i].ur, dir_tab[i].dl, dir_tab[i].dr};
			send_counts(it, dir_tab[i].typed, dir_tab[i].exp);
		end

		// spare index must leave both registers alone
		write_reg(REG_SPARE, 16'h0003);
		send_counts('{24'd40, 24'd7, 24'd10, 24'd3}, 1'b0, R_NONE);

		// random phases, each under one setting
		for (int ph = 0; ph < 10; ph++) begin
			md = mode_t'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0:       pol = 16'd1;
				1:       pol = 16'hFFFF;
				2:       pol = 16'd0;
				default: pol = POL_W'($urandom);
			endcase
			if (ph < 4)
				md = mode_t'(ph);   // every mode gets a phase
			set_cfg(md, pol);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 70; n++) begin
				it.count_up_left    = rand_count();
				it.count_up_right   = rand_count();
				it.count_down_left  = rand_count();
				it.count_down_right = rand_count();
				// close-to-balanced counts give the small asymmetries seen in data
				if ($urandom_range(0, 3) == 0) begin
					it.count_down_left  = it.count_up_left ^ CNT_W'($urandom_range(0, 255));
					it.count_down_right = it.count_up_right ^ CNT_W'($urandom_range(0, 255));
				end
				if (n == 35)
					no_gaps = ~no_gaps;
				send_counts(it, 1'b0, R_NONE);
			end
		end
		start <= 1'b0;

		// drain, then a quiet tail to catch stray strobes
		while (asym_due_q.size() != 0)
			@(posedge clk);
		tail = 0;
		while (tail < TAIL_CYC) begin
			@(posedge clk);
			tail++;
		end

		$display("covered %0d count sets (%0d flagged invalid) over 4 modes, %0d register writes",
			n_items, n_invalid, n_cfg);
		$display("%0d result words checked, %0d mismatches", n_results, n_fail);
		if (n_fail == 0)
			$display("spin_asymmetry_calculator_core regression: pass");
		else
			$display("spin_asymmetry_calculator_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sac_pkg.sv
sv/sac_digit_pipe.sv
sv/spin_asymmetry_calculator_core.sv
sim/tb_spin_asymmetry_calculator_core.sv
